// ===== hdl/sensor_timestamp_aligner_assert.svh =====
// assertion macros for the sensor timestamp aligner
`ifndef SENSOR_TIMESTAMP_ALIGNER_ASSERT_SVH
`define SENSOR_TIMESTAMP_ALIGNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// implication checked at every clock edge outside reset
`define STA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition that must never hold outside reset
`define STA_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define STA_ASSERT(lbl, clk, rstn, prop, msg)
`define STA_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hdl/sta_pkg.sv =====
// shared types, constants and helpers of the sensor timestamp aligner
`default_nettype none
package sta_pkg;

    localparam int TIME_W   = 63;
    localparam int CMD_W    = 3;
    localparam int STREAM_W = 2;
    localparam int CFG_W    = 30;
    localparam int CFG_IDX_W = 2;

    localparam int STA_NUM_STREAMS = 4;

    localparam logic [TIME_W-1:0] STAMP_MAX = {TIME_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX   = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] PAIR_WINDOW_RST = 30'd10000000;
    localparam logic [CFG_W-1:0] FRAME_MIN_RST   = 30'd7000000;
    localparam logic [CFG_W-1:0] FRAME_MAX_RST   = 30'd16000000;

    // item kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_FC_PULSE  = 3'd0,
        CMD_MCU_PULSE = 3'd1,
        CMD_FC_DATA   = 3'd2,
        CMD_MCU_DATA  = 3'd3,
        CMD_CAM_TRIG  = 3'd4,
        CMD_CAM_FRAME = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] pair_window;
        logic [CFG_W-1:0] frame_min;
        logic [CFG_W-1:0] frame_max;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] host;
        logic [TIME_W-1:0] stamp;
    } sync_entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]    kind;
        logic [STREAM_W-1:0] stream;
        logic [TIME_W-1:0]   stamp;
        logic                from_trigger;
    } result_t;

    // address bits for a table of n streams
    function automatic int addr_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // clamp a 65-bit two's complement sum to [0, STAMP_MAX]
    function automatic logic [TIME_W-1:0] sat_stamp(input logic [TIME_W+1:0] v);
        logic [TIME_W-1:0] r;
        if (v[TIME_W+1]) begin
            r = '0;
        end else if (v[TIME_W]) begin
            r = STAMP_MAX;
        end else begin
            r = v[TIME_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sensor_timestamp_aligner.sv =====
// Sensor timestamp aligner: top level with stream ports, config registers and result register.
// An item accepted on s_ is registered in the alignment stage; its result then moves into the result register on m_.
// Throughput: one item per cycle; s_tready drops only while a result waits in the
// alignment stage behind a full, unaccepted result register.
// Reset: config registers return to their defaults and all pulse, offset, trigger and
// per-stream sync valid flags clear at once; the sync point memory is not cleared.
`default_nettype none
module sensor_timestamp_aligner #(
    parameter int NUM_STREAMS = sta_pkg::STA_NUM_STREAMS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // host_time [62:0], hw_time [125:63], zero [127:126]
    input  wire logic [127:0]                    s_tdata,
    // command [2:0], stream [4:3]
    input  wire logic [4:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // stamp [62:0], zero [63]
    output logic [63:0]                          m_tdata,
    // kind [2:0], stream_out [4:3], from_trigger [5]
    output logic [5:0]                           m_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [sta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sta_pkg::CFG_W-1:0]       cfg_wdata
);
    import sta_pkg::*;

    localparam int AW = addr_width(NUM_STREAMS);

    cfg_t        cfg_reg;
    logic        m_valid_reg;
    result_t     m_res_reg;
    logic        out_free;
    logic        res_load;
    result_t     res;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    sync_entry_t rd_entry;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    sync_entry_t wr_entry;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pair_window <= PAIR_WINDOW_RST;
            cfg_reg.frame_min   <= FRAME_MIN_RST;
            cfg_reg.frame_max   <= FRAME_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PAIR_WINDOW: cfg_reg.pair_window <= cfg_wdata;
                REG_FRAME_MIN:   cfg_reg.frame_min   <= cfg_wdata;
                REG_FRAME_MAX:   cfg_reg.frame_max   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // alignment stage
    sta_align_core #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[2:0]),
        .in_stream (s_tuser[4:3]),
        .in_host   (s_tdata[62:0]),
        .in_hw     (s_tdata[125:63]),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry)
    );

    // sync point storage
    sta_sync_mem #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // result register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.stamp};
    assign m_tuser  = {m_res_reg.from_trigger, m_res_reg.stream, m_res_reg.kind};

endmodule
`default_nettype wire

// ===== hdl/sta_sync_mem.sv =====
// per-stream sync point memory with registered read and write forwarding
`default_nettype none
module sta_sync_mem #(
    parameter int NUM_STREAMS = sta_pkg::STA_NUM_STREAMS,
    localparam int AW = sta_pkg::addr_width(NUM_STREAMS)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output sta_pkg::sync_entry_t       rd_entry,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  sta_pkg::sync_entry_t       wr_entry
);
    import sta_pkg::*;

    sync_entry_t mem [NUM_STREAMS];
    sync_entry_t rd_data_reg;
    sync_entry_t fwd_data_reg;
    logic        fwd_hit_reg;

    // storage write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // read port, captured with the item that asks for it
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_entry;
        end
    end

    // a write in the same cycle as the read wins over the stale array data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule
`default_nettype wire

// ===== hdl/sta_align_core.sv =====
// alignment stage: clock offset, trigger and sync point logic
`default_nettype none
`include "sensor_timestamp_aligner_assert.svh"
module sta_align_core #(
    parameter int NUM_STREAMS = sta_pkg::STA_NUM_STREAMS,
    localparam int AW = sta_pkg::addr_width(NUM_STREAMS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sta_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [sta_pkg::STREAM_W-1:0]  in_stream,
    input  wire logic [sta_pkg::TIME_W-1:0]    in_host,
    input  wire logic [sta_pkg::TIME_W-1:0]    in_hw,
    input  sta_pkg::cfg_t                      cfg,
    input  wire logic                          out_free,
    output logic                               res_load,
    output sta_pkg::result_t                   res,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  sta_pkg::sync_entry_t               rd_entry,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output sta_pkg::sync_entry_t               wr_entry
);
    import sta_pkg::*;

    localparam int SX_W = 5;

    // stage registers
    logic                s1_valid_reg;
    logic [CMD_W-1:0]    s1_cmd_reg;
    logic [STREAM_W-1:0] s1_stream_reg;
    logic [TIME_W-1:0]   s1_host_reg;
    logic [TIME_W-1:0]   s1_hw_reg;

    // clock state
    logic [TIME_W-1:0]   fc_host_reg, fc_host_next;
    logic [TIME_W-1:0]   fc_hw_reg, fc_hw_next;
    logic                fc_seen_reg, fc_seen_next;
    logic [TIME_W-1:0]   mcu_host_reg, mcu_host_next;
    logic [TIME_W-1:0]   mcu_hw_reg, mcu_hw_next;
    logic                mcu_seen_reg, mcu_seen_next;
    logic [TIME_W:0]     offset_reg, offset_next;
    logic                offset_valid_reg, offset_valid_next;
    logic [TIME_W-1:0]   trig_host_reg, trig_host_next;
    logic [TIME_W-1:0]   trig_stamp_reg, trig_stamp_next;
    logic                trig_valid_reg, trig_valid_next;
    logic [NUM_STREAMS-1:0] sync_valid_reg, sync_valid_next;

    logic                accept;
    logic                go;
    logic                res_valid;
    logic                s1_valid_next;
    logic [SX_W-1:0]     s1_sx;
    logic [SX_W-1:0]     in_sx;
    logic [AW-1:0]       s1_addr;
    logic                in_range;
    logic                sync_ok;
    logic [TIME_W+1:0]   corr_sum;
    logic [TIME_W-1:0]   corr_stamp;
    logic [TIME_W+1:0]   extr_sum;
    logic [TIME_W:0]     frame_dly;
    logic                frame_after;
    logic                in_win;
    logic [TIME_W-1:0]   peer_host;
    logic [TIME_W-1:0]   host_diff;
    logic                peer_seen;
    logic                pair_ok;
    logic [TIME_W:0]     pair_offset;

    // handshake and stage advance
    assign go       = s1_valid_reg && (!res_valid || out_free);
    assign in_ready = !s1_valid_reg || go;
    assign accept   = in_valid && in_ready;
    assign res_load = go && res_valid;

    assign in_sx   = {{(SX_W-STREAM_W){1'b0}}, in_stream};
    assign s1_sx   = {{(SX_W-STREAM_W){1'b0}}, s1_stream_reg};
    assign rd_en   = accept;
    assign rd_addr = in_sx[AW-1:0];
    assign s1_addr = s1_sx[AW-1:0];
    assign in_range = s1_sx < SX_W'(NUM_STREAMS);
    assign sync_ok  = in_range && sync_valid_reg[s1_addr];

    // offset correction of the hardware time
    assign corr_sum   = {2'b00, s1_hw_reg} + {offset_reg[TIME_W], offset_reg};
    assign corr_stamp = sat_stamp(corr_sum);

    // extrapolation from the stream's sync point
    assign extr_sum = {2'b00, rd_entry.stamp} + {2'b00, s1_host_reg}
                    - {2'b00, rd_entry.host};

    // frame delay after the trigger
    assign frame_dly   = {1'b0, s1_host_reg} - {1'b0, trig_host_reg};
    assign frame_after = s1_host_reg > trig_host_reg;
    assign in_win = frame_after
                 && (frame_dly[TIME_W-1:0] > {{(TIME_W-CFG_W){1'b0}}, cfg.frame_min})
                 && (frame_dly[TIME_W-1:0] <= {{(TIME_W-CFG_W){1'b0}}, cfg.frame_max});

    // pulse pairing against the latest pulse of the other clock
    assign peer_host = (s1_cmd_reg == CMD_FC_PULSE) ? mcu_host_reg : fc_host_reg;
    assign peer_seen = (s1_cmd_reg == CMD_FC_PULSE) ? mcu_seen_reg : fc_seen_reg;
    assign host_diff = (s1_host_reg > peer_host) ? (s1_host_reg - peer_host)
                                                 : (peer_host - s1_host_reg);
    assign pair_ok   = peer_seen
                    && (host_diff < {{(TIME_W-CFG_W){1'b0}}, cfg.pair_window});
    assign pair_offset = (s1_cmd_reg == CMD_FC_PULSE)
                       ? ({1'b0, s1_hw_reg} - {1'b0, mcu_hw_reg})
                       : ({1'b0, fc_hw_reg} - {1'b0, s1_hw_reg});

    // per-item decision
    always_comb begin
        fc_host_next      = fc_host_reg;
        fc_hw_next        = fc_hw_reg;
        fc_seen_next      = fc_seen_reg;
        mcu_host_next     = mcu_host_reg;
        mcu_hw_next       = mcu_hw_reg;
        mcu_seen_next     = mcu_seen_reg;
        offset_next       = offset_reg;
        offset_valid_next = offset_valid_reg;
        trig_host_next    = trig_host_reg;
        trig_stamp_next   = trig_stamp_reg;
        trig_valid_next   = trig_valid_reg;
        sync_valid_next   = sync_valid_reg;
        res_valid         = 1'b0;
        res.kind          = s1_cmd_reg;
        res.stream        = s1_stream_reg;
        res.stamp         = s1_hw_reg;
        res.from_trigger  = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = s1_addr;
        wr_entry.host     = s1_host_reg;
        wr_entry.stamp    = trig_stamp_reg;
        case (s1_cmd_reg)
            CMD_FC_PULSE: begin
                fc_seen_next = 1'b1;
                fc_host_next = s1_host_reg;
                fc_hw_next   = s1_hw_reg;
                if (pair_ok) begin
                    offset_next       = pair_offset;
                    offset_valid_next = 1'b1;
                end
            end
            CMD_MCU_PULSE: begin
                mcu_seen_next = 1'b1;
                mcu_host_next = s1_host_reg;
                mcu_hw_next   = s1_hw_reg;
                if (pair_ok) begin
                    offset_next       = pair_offset;
                    offset_valid_next = 1'b1;
                end
            end
            CMD_FC_DATA: begin
                res_valid = offset_valid_reg;
            end
            CMD_MCU_DATA: begin
                res_valid = offset_valid_reg;
                res.stamp = corr_stamp;
            end
            CMD_CAM_TRIG: begin
                if (offset_valid_reg) begin
                    trig_valid_next = 1'b1;
                    trig_stamp_next = corr_stamp;
                    trig_host_next  = s1_host_reg;
                end
            end
            CMD_CAM_FRAME: begin
                if (in_range && trig_valid_reg) begin
                    if (in_win) begin
                        res_valid        = 1'b1;
                        res.stamp        = trig_stamp_reg;
                        res.from_trigger = 1'b1;
                        wr_en            = go;
                        sync_valid_next[s1_addr] = 1'b1;
                    end else if (sync_ok) begin
                        res_valid = 1'b1;
                        res.stamp = sat_stamp(extr_sum);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign s1_valid_next = accept ? 1'b1 : (go ? 1'b0 : s1_valid_reg);

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg    <= in_cmd;
            s1_stream_reg <= in_stream;
            s1_host_reg   <= in_host;
            s1_hw_reg     <= in_hw;
        end
    end

    // control and clock state, updated once per item as it leaves the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            fc_host_reg      <= '0;
            fc_hw_reg        <= '0;
            fc_seen_reg      <= 1'b0;
            mcu_host_reg     <= '0;
            mcu_hw_reg       <= '0;
            mcu_seen_reg     <= 1'b0;
            offset_reg       <= '0;
            offset_valid_reg <= 1'b0;
            trig_host_reg    <= '0;
            trig_stamp_reg   <= '0;
            trig_valid_reg   <= 1'b0;
            sync_valid_reg   <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (go) begin
                fc_host_reg      <= fc_host_next;
                fc_hw_reg        <= fc_hw_next;
                fc_seen_reg      <= fc_seen_next;
                mcu_host_reg     <= mcu_host_next;
                mcu_hw_reg       <= mcu_hw_next;
                mcu_seen_reg     <= mcu_seen_next;
                offset_reg       <= offset_next;
                offset_valid_reg <= offset_valid_next;
                trig_host_reg    <= trig_host_next;
                trig_stamp_reg   <= trig_stamp_next;
                trig_valid_reg   <= trig_valid_next;
                sync_valid_reg   <= sync_valid_next;
            end
        end
    end

    // checks
    `STA_ASSERT(a_wr_on_advance, aclk, aresetn, wr_en |-> go && in_range, "sync write outside an advancing frame")
    `STA_NEVER(a_offset_sticky, aclk, aresetn, $fell(offset_valid_reg), "offset valid dropped")
    `STA_ASSERT(a_trig_needs_offset, aclk, aresetn, trig_valid_reg |-> offset_valid_reg, "trigger stored without offset")
    `STA_ASSERT(a_stall_holds, aclk, aresetn, (s1_valid_reg && !go) |=> (s1_valid_reg && $stable(s1_cmd_reg) && $stable(s1_host_reg)), "stalled item lost")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench of the sensor timestamp aligner: directed rows, then randomized phases with stalls
module testbench;
    import sta_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 240;
    localparam int NUM_PHASES  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [CMD_W-1:0]     CMD_RSVD6    = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_RSVD7    = 3'd7;
    localparam logic [CFG_W-1:0]     CFG_ALL_ONES = {CFG_W{1'b1}};

    // how a directed row is checked
    typedef enum logic [1:0] {BY_PREDICTOR, NO_RESULT, FIXED_RESULT} row_check_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STREAM_W-1:0] strm;
        logic [TIME_W-1:0]   host;
        logic [TIME_W-1:0]   hw;
        row_check_t          chk;
        logic [TIME_W-1:0]   stamp;
        logic                from_trig;
    } steer_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [127:0]         s_tdata;
    logic [4:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic [5:0]           m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    sensor_timestamp_aligner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the configuration
    logic [CFG_W-1:0] win_ns  = PAIR_WINDOW_RST;
    logic [CFG_W-1:0] fmin_ns = FRAME_MIN_RST;
    logic [CFG_W-1:0] fmax_ns = FRAME_MAX_RST;

    // predictor copy of the alignment state
    logic [TIME_W-1:0] fcp_host = '0;
    logic [TIME_W-1:0] fcp_hw = '0;
    bit                fcp_seen = 1'b0;
    logic [TIME_W-1:0] mcup_host = '0;
    logic [TIME_W-1:0] mcup_hw = '0;
    bit                mcup_seen = 1'b0;
    logic [63:0]       hw_offset = '0;
    bit                offset_ok = 1'b0;
    logic [TIME_W-1:0] trig_host = '0;
    logic [TIME_W-1:0] trig_stamp = '0;
    bit                trig_ok = 1'b0;
    logic [TIME_W-1:0] sync_host_t [STA_NUM_STREAMS];
    logic [TIME_W-1:0] sync_stamp_t [STA_NUM_STREAMS];
    bit                sync_ok [STA_NUM_STREAMS];

    result_t    stamps_due [$];
    steer_row_t steer_rows [27];
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;
    int         items_sent = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    logic [63:0] host_now;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // clamp a signed 65-bit sum into the stamp range
    function automatic logic [TIME_W-1:0] clamp_stamp(input logic signed [TIME_W+1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > $signed({2'b00, STAMP_MAX})) begin
            return STAMP_MAX;
        end
        return v[TIME_W-1:0];
    endfunction

    // hardware time moved onto the fc clock by the latched offset
    function automatic logic [TIME_W-1:0] offset_hw(input logic [TIME_W-1:0] hw);
        return clamp_stamp($signed({2'b00, hw}) + $signed({hw_offset[63], hw_offset}));
    endfunction

    // latch the offset when both pulses are seen close enough in host time
    function automatic void try_lock();
        logic [TIME_W-1:0] d;
        if (!fcp_seen || !mcup_seen) begin
            return;
        end
        d = (mcup_host > fcp_host) ? mcup_host - fcp_host : fcp_host - mcup_host;
        if (d < {33'd0, win_ns}) begin
            hw_offset = {1'b0, fcp_hw} - {1'b0, mcup_hw};
            offset_ok = 1'b1;
        end
    endfunction

    // predicted effect of one accepted item, with the result it causes if any
    function automatic void align_predict(input logic [CMD_W-1:0] cmd,
            input logic [STREAM_W-1:0] strm, input logic [TIME_W-1:0] host,
            input logic [TIME_W-1:0] hw, output bit made, output result_t r);
        logic [TIME_W-1:0] d;
        bit in_win;
        made = 1'b0;
        r = '{kind: cmd, stream: strm, stamp: '0, from_trigger: 1'b0};
        case (cmd)
            CMD_FC_PULSE: begin
                fcp_seen = 1'b1;
                fcp_host = host;
                fcp_hw = hw;
                try_lock();
            end
            CMD_MCU_PULSE: begin
                mcup_seen = 1'b1;
                mcup_host = host;
                mcup_hw = hw;
                try_lock();
            end
            CMD_FC_DATA: begin
                made = offset_ok;
                r.stamp = hw;
            end
            CMD_MCU_DATA: begin
                made = offset_ok;
                r.stamp = offset_hw(hw);
            end
            CMD_CAM_TRIG: begin
                if (offset_ok) begin
                    trig_ok = 1'b1;
                    trig_stamp = offset_hw(hw);
                    trig_host = host;
                end
            end
            CMD_CAM_FRAME: begin
                if (trig_ok && int'(strm) < STA_NUM_STREAMS) begin
                    in_win = 1'b0;
                    if (host > trig_host) begin
                        d = host - trig_host;
                        in_win = (d > {33'd0, fmin_ns}) && (d <= {33'd0, fmax_ns});
                    end
                    if (in_win) begin
                        made = 1'b1;
                        r.stamp = trig_stamp;
                        r.from_trigger = 1'b1;
                        sync_ok[strm] = 1'b1;
                        sync_host_t[strm] = host;
                        sync_stamp_t[strm] = trig_stamp;
                    end else if (sync_ok[strm]) begin
                        // extrapolate from the stream's last sync point
                        made = 1'b1;
                        r.stamp = clamp_stamp($signed({2'b00, sync_stamp_t[strm]})
                            + $signed({2'b00, host}) - $signed({2'b00, sync_host_t[strm]}));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_cnt < 40) begin
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        end
        mismatch_cnt++;
    endtask

    // drive one item, wait for its handshake and record what it should cause
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [STREAM_W-1:0] strm,
            input logic [TIME_W-1:0] host, input logic [TIME_W-1:0] hw,
            input row_check_t chk, input logic [TIME_W-1:0] want_stamp,
            input logic want_from);
        bit made;
        result_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, hw, host};
        s_tuser <= {strm, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        align_predict(cmd, strm, host, hw, made, r);
        case (chk)
            BY_PREDICTOR: begin
                if (made) stamps_due.push_back(r);
            end
            FIXED_RESULT: begin
                stamps_due.push_back('{kind: cmd, stream: strm, stamp: want_stamp,
                                       from_trigger: want_from});
            end
            default: ;
        endcase
        if (cmd <= CMD_CAM_FRAME) items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [STREAM_W-1:0] strm,
            input logic [TIME_W-1:0] host, input logic [TIME_W-1:0] hw);
        push_item(cmd, strm, host, hw, BY_PREDICTOR, '0, 1'b0);
    endtask

    function automatic logic [TIME_W-1:0] rand63();
        logic [63:0] v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] rand40();
        return {23'd0, 8'($urandom_range(255)), 32'($urandom)};
    endfunction

    // register write, the enable is lowered by the caller after the last one
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PAIR_WINDOW: win_ns = val;
            REG_FRAME_MIN:   fmin_ns = val;
            REG_FRAME_MAX:   fmax_ns = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // stop sending and let every expected result and the pipeline drain
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stamps_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    // random traffic, mostly well-formed pulse pairs, data, triggers and frames
    task automatic run_random(input int n);
        int start;
        int pick;
        int k;
        logic [63:0] dd;
        logic [63:0] t;
        logic [TIME_W-1:0] wa;
        logic [TIME_W-1:0] wb;
        logic [STREAM_W-1:0] sx;
        logic [CMD_W-1:0] cx;
        start = items_sent;
        while (items_sent - start < n) begin
            pick = $urandom_range(99);
            sx = STREAM_W'($urandom_range(3));
            host_now = host_now + 64'($urandom_range(1, 3000000));
            if (pick < 15) begin
                // pulse pair around the pair window edge
                k = $urandom_range(3);
                case (k)
                    0: dd = 64'($urandom_range(0, int'(win_ns) + 2));
                    1: dd = (win_ns == 0) ? 64'd0 : {34'd0, win_ns} - 64'd1;
                    2: dd = {34'd0, win_ns};
                    default: dd = {34'd0, win_ns} + 64'd1;
                endcase
                t = $urandom_range(1) ? host_now + dd : host_now - dd;
                if ($urandom_range(1)) begin
                    wa = rand63();
                    wb = rand63();
                end else begin
                    wa = rand40();
                    wb = rand40();
                end
                if ($urandom_range(1)) begin
                    send_item(CMD_FC_PULSE, sx, host_now[TIME_W-1:0], wa);
                    send_item(CMD_MCU_PULSE, sx, t[TIME_W-1:0], wb);
                end else begin
                    send_item(CMD_MCU_PULSE, sx, t[TIME_W-1:0], wb);
                    send_item(CMD_FC_PULSE, sx, host_now[TIME_W-1:0], wa);
                end
            end else if (pick < 40) begin
                // fc or mcu data
                k = $urandom_range(9);
                case (k)
                    0: wa = STAMP_MAX;
                    1: wa = '0;
                    2, 3: wa = rand63();
                    default: wa = rand40();
                endcase
                cx = $urandom_range(1) ? CMD_MCU_DATA : CMD_FC_DATA;
                send_item(cx, sx, host_now[TIME_W-1:0], wa);
            end else if (pick < 52) begin
                wa = $urandom_range(3) == 0 ? rand63() : rand40();
                send_item(CMD_CAM_TRIG, sx, host_now[TIME_W-1:0], wa);
            end else if (pick < 85) begin
                // frame placed relative to the last trigger, often on a window edge
                k = $urandom_range(7);
                case (k)
                    0: dd = {34'd0, fmin_ns};
                    1: dd = {34'd0, fmin_ns} + 64'd1;
                    2: dd = {34'd0, fmax_ns};
                    3: dd = {34'd0, fmax_ns} + 64'd1;
                    4, 5: begin
                        if (fmax_ns > fmin_ns) begin
                            dd = {34'd0, fmin_ns}
                                + 64'($urandom_range(0, int'(fmax_ns - fmin_ns)));
                        end else begin
                            dd = 64'($urandom_range(0, 40000000));
                        end
                    end
                    6: dd = 64'($urandom);
                    default: dd = 64'd0 - 64'($urandom_range(1, 40000000));
                endcase
                t = {1'b0, trig_host} + dd;
                send_item(CMD_CAM_FRAME, sx, t[TIME_W-1:0], rand63());
            end else if (pick < 95) begin
                // noise over every command code and full-width times
                cx = CMD_W'($urandom_range(int'(CMD_RSVD7), int'(CMD_FC_PULSE)));
                send_item(cx, sx, rand63(), rand63());
            end else begin
                // lone pulse far from its partner
                t = host_now + 64'd500000000;
                cx = $urandom_range(1) ? CMD_MCU_PULSE : CMD_FC_PULSE;
                send_item(cx, sx, t[TIME_W-1:0], rand40());
            end
        end
    endtask

    // receiver stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stamps_due.size() == 0) begin
                flag_mismatch("result arrived with nothing expected");
            end else begin
                want = stamps_due.pop_front();
                if (m_tuser[CMD_W-1:0] !== want.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d",
                        m_tuser[CMD_W-1:0], want.kind));
                if (m_tuser[CMD_W+STREAM_W-1:CMD_W] !== want.stream)
                    flag_mismatch($sformatf("stream %0d, expected %0d",
                        m_tuser[CMD_W+STREAM_W-1:CMD_W], want.stream));
                if (m_tdata[TIME_W-1:0] !== want.stamp)
                    flag_mismatch($sformatf("stamp %0d, expected %0d",
                        m_tdata[TIME_W-1:0], want.stamp));
                if (m_tuser[CMD_W+STREAM_W] !== want.from_trigger)
                    flag_mismatch($sformatf("from_trigger %0b, expected %0b",
                        m_tuser[CMD_W+STREAM_W], want.from_trigger));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // stimulus
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        foreach (sync_ok[i]) begin
            sync_ok[i] = 1'b0;
            sync_host_t[i] = '0;
            sync_stamp_t[i] = '0;
        end
        host_now = 64'd6000000000;

        // directed rows on the reset configuration
        steer_rows = '{
            // nothing passes before the offset is latched
            '{CMD_FC_DATA,   2'd0, 63'd100,        63'd5,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_DATA,  2'd1, 63'd200,        63'd6,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_TRIG,  2'd2, 63'd300,        63'd7,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_FRAME, 2'd0, 63'd20000000,   63'd0,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_RSVD6,     2'd3, STAMP_MAX,      STAMP_MAX, NO_RESULT, 63'd0, 1'b0},
            // first mcu pulse too far in host time, second one pairs
            '{CMD_FC_PULSE,  2'd0, 63'd1000000000, 63'd5000000000, NO_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_PULSE, 2'd0, 63'd1020000000, 63'd2000000000, NO_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_PULSE, 2'd1, 63'd1005000000, 63'd2000000000, NO_RESULT, 63'd0, 1'b0},
            '{CMD_FC_DATA,   2'd3, 63'd1100000000, STAMP_MAX, FIXED_RESULT, STAMP_MAX, 1'b0},
            '{CMD_FC_DATA,   2'd0, 63'd1100000001, 63'd0,     FIXED_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_DATA,  2'd2, 63'd1100000002, 63'd1000,
              FIXED_RESULT, 63'd3000001000, 1'b0},
            '{CMD_MCU_DATA,  2'd1, 63'd1100000003, STAMP_MAX, FIXED_RESULT, STAMP_MAX, 1'b0},
            // most negative offset clamps to zero
            '{CMD_FC_PULSE,  2'd0, 63'd2000000000, 63'd0,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_PULSE, 2'd0, 63'd2000000000, STAMP_MAX, NO_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_DATA,  2'd0, 63'd2000000100, 63'd5,     FIXED_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_DATA,  2'd3, 63'd2000000200, STAMP_MAX, FIXED_RESULT, 63'd0, 1'b0},
            // offset of one second, then a trigger and its frames
            '{CMD_FC_PULSE,  2'd0, 63'd3000000000, 63'd1000000000, NO_RESULT, 63'd0, 1'b0},
            '{CMD_MCU_PULSE, 2'd0, 63'd3000000000, 63'd0,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_TRIG,  2'd0, 63'd4000000000, 63'd500,   NO_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_FRAME, 2'd1, 63'd4010000000, 63'd0,
              FIXED_RESULT, 63'd1000000500, 1'b1},
            // delay equal to the minimum does not sync
            '{CMD_CAM_FRAME, 2'd1, 63'd4007000000, 63'd0,     BY_PREDICTOR, 63'd0, 1'b0},
            // delay equal to the maximum syncs
            '{CMD_CAM_FRAME, 2'd1, 63'd4016000000, 63'd0,
              FIXED_RESULT, 63'd1000000500, 1'b1},
            // frame before the trigger on a stream with no sync point
            '{CMD_CAM_FRAME, 2'd2, 63'd3000000000, 63'd0,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_FRAME, 2'd1, 63'd0,          63'd0,     FIXED_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_FRAME, 2'd3, STAMP_MAX,      63'd0,     NO_RESULT, 63'd0, 1'b0},
            '{CMD_CAM_FRAME, 2'd1, STAMP_MAX,      63'd0,     BY_PREDICTOR, 63'd0, 1'b0},
            '{CMD_CAM_FRAME, 2'd0, 63'd4007000001, STAMP_MAX,
              FIXED_RESULT, 63'd1000000500, 1'b1}
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (steer_rows[i]) begin
            push_item(steer_rows[i].cmd, steer_rows[i].strm, steer_rows[i].host,
                      steer_rows[i].hw, steer_rows[i].chk, steer_rows[i].stamp,
                      steer_rows[i].from_trig);
        end

        // random phases, each with its own configuration and idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                case (ph)
                    1: begin
                        put_reg(REG_PAIR_WINDOW, CFG_ALL_ONES);
                        put_reg(REG_FRAME_MIN, '0);
                        put_reg(REG_FRAME_MAX, CFG_ALL_ONES);
                    end
                    2: begin
                        // no pairing, empty frame window
                        put_reg(REG_PAIR_WINDOW, '0);
                        put_reg(REG_FRAME_MIN, 30'd5000);
                        put_reg(REG_FRAME_MAX, 30'd5000);
                    end
                    3: begin
                        put_reg(REG_PAIR_WINDOW, 30'd1000);
                        put_reg(REG_FRAME_MIN, CFG_ALL_ONES);
                        put_reg(REG_FRAME_MAX, '0);
                    end
                    5: begin
                        put_reg(REG_PAIR_WINDOW, PAIR_WINDOW_RST);
                        put_reg(REG_FRAME_MIN, FRAME_MIN_RST);
                        put_reg(REG_FRAME_MAX, FRAME_MAX_RST);
                    end
                    default: begin
                        put_reg(REG_PAIR_WINDOW, CFG_W'($urandom_range(1, 30000000)));
                        put_reg(REG_FRAME_MIN, CFG_W'($urandom_range(0, 15000000)));
                        put_reg(REG_FRAME_MAX,
                                fmin_ns + CFG_W'($urandom_range(0, 20000000)));
                        if (ph == 4) put_reg(REG_UNUSED, CFG_W'($urandom));
                    end
                endcase
                cfg_we <= 1'b0;
            end
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 78;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 78;
                end
                default: begin
                    src_idle_pct = 35;
                    sink_stall_pct = 35;
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatch_cnt == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sta_pkg.sv
hdl/sta_sync_mem.sv
hdl/sta_align_core.sv
hdl/sensor_timestamp_aligner.sv
tb/sv/testbench.sv
